FILE: src/websocket_frame_deframer_core_defines.svh
// Assertion macros for the WebSocket frame deframer.
// Included by the top level; depends on nothing else.
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WSDF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WSDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/wsdf_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
// Used by websocket_frame_deframer_core; depends on nothing.
`default_nettype none

package wsdf_pkg;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXTLEN,
      PH_KEY,
      PH_PAYLOAD,
      PH_SKIP
   } phase_type;

   typedef enum logic [1:0] {
      VERDICT_OK,
      VERDICT_INCOMPLETE,
      VERDICT_CLOSE,
      VERDICT_IGNORED
   } verdict_type;

   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_TEXT  = 4'h1;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   localparam logic [3:0] EXT16_BYTES  = 4'd2;
   localparam logic [3:0] EXT64_BYTES  = 4'd8;
   localparam logic [3:0] MASK_KEY_LEN = 4'd4;

   localparam int unsigned RESULT_DEPTH = 4;
   localparam int unsigned RESULT_PTR_W = 2;
   localparam int unsigned RESULT_CNT_W = 3;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       is_status;
      logic [1:0] status;
   } result_type;

endpackage

`default_nettype wire

FILE: src/websocket_frame_deframer_core.sv
// Top level of the WebSocket frame deframer: header parser, unmasking and result queue.
// Depends on wsdf_pkg and websocket_frame_deframer_core_defines.svh.
//
//   channel | direction | handshake            | beat
//   req     | in        | req_valid, req_stall | buffer_byte, buffer_end
//   rsp     | out       | rsp_valid, rsp_stall | payload_byte, is_status, status
//
// One byte is taken per cycle while req_stall is low; its results enter a four-entry result queue at the same edge.
// A byte yields at most two results, so req_stall rises while fewer than two slots are free.
// The first result of a byte can leave on the cycle after the byte is taken.
// Reset is synchronous and returns the parser to the first header byte with an empty queue.
// Stalls on rsp back up only through the queue fill level.
`default_nettype none
`include "websocket_frame_deframer_core_defines.svh"

module websocket_frame_deframer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_buffer_byte,
   input  logic       req_buffer_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_is_status,
   output logic [1:0] rsp_status
);

   wsdf_pkg::phase_type   phase_ff, phase_in;
   wsdf_pkg::verdict_type verdict_ff, verdict_in, verdict_step;
   logic [3:0]            opcode_ff, opcode_in;
   logic                  mask_ff, mask_in;
   logic [63:0]           len_ff, len_in;
   logic [3:0]            hdr_cnt_ff, hdr_cnt_in;
   logic [31:0]           key_ff, key_in;
   logic [1:0]            kidx_ff, kidx_in;

   logic        accept;
   logic [6:0]  len7;
   logic [63:0] ext_len;
   logic        finish_len;
   logic        start_payload;
   logic        new_len_zero;
   logic [7:0]  key_byte;

   wsdf_pkg::result_type fifo_ff [wsdf_pkg::RESULT_DEPTH];
   logic [wsdf_pkg::RESULT_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in, wr_next_ptr;
   logic [wsdf_pkg::RESULT_CNT_W-1:0] cnt_ff, cnt_in;
   wsdf_pkg::result_type first_res, second_res;
   logic       push_first, push_second, pop;
   logic [1:0] push_cnt;

   assign accept  = req_valid && !req_stall;
   assign len7    = req_buffer_byte[6:0];
   assign ext_len = {len_ff[55:0], req_buffer_byte};

   always_comb begin
      phase_in      = phase_ff;
      verdict_step  = verdict_ff;
      opcode_in     = opcode_ff;
      mask_in       = mask_ff;
      len_in        = len_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      key_in        = key_ff;
      kidx_in       = kidx_ff;
      finish_len    = 1'b0;
      start_payload = 1'b0;
      new_len_zero  = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            wsdf_pkg::PH_HDR0: begin
               opcode_in = req_buffer_byte[3:0];
               phase_in  = wsdf_pkg::PH_HDR1;
            end
            wsdf_pkg::PH_HDR1: begin
               mask_in = req_buffer_byte[7];
               key_in  = '0;
               if (len7 == wsdf_pkg::LEN7_EXT16) begin
                  len_in     = '0;
                  hdr_cnt_in = wsdf_pkg::EXT16_BYTES;
                  phase_in   = wsdf_pkg::PH_EXTLEN;
               end else if (len7 == wsdf_pkg::LEN7_EXT64) begin
                  len_in     = '0;
                  hdr_cnt_in = wsdf_pkg::EXT64_BYTES;
                  phase_in   = wsdf_pkg::PH_EXTLEN;
               end else begin
                  len_in       = {57'd0, len7};
                  finish_len   = 1'b1;
                  new_len_zero = (len7 == 7'd0);
               end
            end
            wsdf_pkg::PH_EXTLEN: begin
               len_in     = ext_len;
               hdr_cnt_in = hdr_cnt_ff - 4'd1;
               if (hdr_cnt_ff == 4'd1) begin
                  finish_len   = 1'b1;
                  new_len_zero = (ext_len == 64'd0);
               end
            end
            wsdf_pkg::PH_KEY: begin
               key_in     = {key_ff[23:0], req_buffer_byte};
               hdr_cnt_in = hdr_cnt_ff - 4'd1;
               if (hdr_cnt_ff == 4'd1) begin
                  start_payload = 1'b1;
                  new_len_zero  = (len_ff == 64'd0);
               end
            end
            wsdf_pkg::PH_PAYLOAD: begin
               len_in  = len_ff - 64'd1;
               kidx_in = kidx_ff + 2'd1;
               if (len_ff == 64'd1) begin
                  verdict_step = wsdf_pkg::VERDICT_OK;
                  phase_in     = wsdf_pkg::PH_SKIP;
               end
            end
            default: begin
            end
         endcase
         if (finish_len) begin
            priority if (opcode_ff == wsdf_pkg::OP_CLOSE) begin
               verdict_step = wsdf_pkg::VERDICT_CLOSE;
               phase_in     = wsdf_pkg::PH_SKIP;
            end else if (opcode_ff != wsdf_pkg::OP_TEXT) begin
               verdict_step = wsdf_pkg::VERDICT_IGNORED;
               phase_in     = wsdf_pkg::PH_SKIP;
            end else if (mask_in) begin
               hdr_cnt_in = wsdf_pkg::MASK_KEY_LEN;
               phase_in   = wsdf_pkg::PH_KEY;
            end else begin
               start_payload = 1'b1;
            end
         end
         if (start_payload) begin
            kidx_in = 2'd0;
            if (new_len_zero) begin
               verdict_step = wsdf_pkg::VERDICT_OK;
               phase_in     = wsdf_pkg::PH_SKIP;
            end else begin
               phase_in = wsdf_pkg::PH_PAYLOAD;
            end
         end
         if (req_buffer_end) begin
            phase_in = wsdf_pkg::PH_HDR0;
         end
      end
   end

   assign verdict_in = (accept && req_buffer_end) ? wsdf_pkg::VERDICT_INCOMPLETE : verdict_step;

   always_comb begin
      unique case (kidx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // Results of the current beat: a payload byte first, then the status.
   always_comb begin
      first_res   = '0;
      second_res  = '0;
      push_first  = 1'b0;
      push_second = 1'b0;
      if (accept) begin
         if (phase_ff == wsdf_pkg::PH_PAYLOAD) begin
            push_first               = 1'b1;
            first_res.payload_byte   = req_buffer_byte ^ key_byte;
            if (req_buffer_end) begin
               push_second          = 1'b1;
               second_res.is_status = 1'b1;
               second_res.status    = verdict_step;
            end
         end else if (req_buffer_end) begin
            push_first          = 1'b1;
            first_res.is_status = 1'b1;
            first_res.status    = verdict_step;
         end
      end
   end

   assign push_cnt    = {1'b0, push_first} + {1'b0, push_second};
   assign pop         = rsp_valid && !rsp_stall;
   assign wr_next_ptr = wr_ff + wsdf_pkg::RESULT_PTR_W'(1);
   assign wr_in       = wr_ff + push_cnt;
   assign rd_in       = rd_ff + {1'b0, pop};
   assign cnt_in      = cnt_ff + {1'b0, push_cnt} - {2'b00, pop};

   assign req_stall        = cnt_ff > wsdf_pkg::RESULT_CNT_W'(wsdf_pkg::RESULT_DEPTH - 2);
   assign rsp_valid        = cnt_ff != '0;
   assign rsp_payload_byte = fifo_ff[rd_ff].payload_byte;
   assign rsp_is_status    = fifo_ff[rd_ff].is_status;
   assign rsp_status       = fifo_ff[rd_ff].status;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= wsdf_pkg::PH_HDR0;
         verdict_ff <= wsdf_pkg::VERDICT_INCOMPLETE;
         wr_ff      <= '0;
         rd_ff      <= '0;
         cnt_ff     <= '0;
      end else begin
         phase_ff   <= phase_in;
         verdict_ff <= verdict_in;
         wr_ff      <= wr_in;
         rd_ff      <= rd_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff  <= opcode_in;
      mask_ff    <= mask_in;
      len_ff     <= len_in;
      hdr_cnt_ff <= hdr_cnt_in;
      key_ff     <= key_in;
      kidx_ff    <= kidx_in;
      if (push_first) begin
         fifo_ff[wr_ff] <= first_res;
      end
      if (push_second) begin
         fifo_ff[wr_next_ptr] <= second_res;
      end
   end

   `WSDF_ASSERT_SAME(a_queue_bound, clock, reset, 1'b1,
      cnt_ff <= wsdf_pkg::RESULT_CNT_W'(wsdf_pkg::RESULT_DEPTH), "result queue overfilled")
   `WSDF_ASSERT_NEXT(a_end_restarts, clock, reset, accept && req_buffer_end,
      phase_ff == wsdf_pkg::PH_HDR0 && verdict_ff == wsdf_pkg::VERDICT_INCOMPLETE,
      "buffer end did not restart the parser")
   `WSDF_ASSERT_NEXT(a_payload_queued, clock, reset, accept && phase_ff == wsdf_pkg::PH_PAYLOAD,
      rsp_valid, "payload beat left no result")

endmodule

`default_nettype wire
